### rtl/core/blif_pkg.sv
package blif_pkg;

  localparam int MAX_CPUS         = 4;
  localparam int CPU_W            = 2;
  localparam int LINE_OFFSET_BITS = 6;
  localparam int ADDRESS_BITS     = 32;
  localparam int LINE_W           = 26;
  localparam int CPU_COUNT_W      = 3;
  localparam int CMD_FIFO_DEPTH   = 2;

  typedef enum logic [1:0] {
    OP_IFETCH = 2'd0,
    OP_READ   = 2'd1,
    OP_WRITE  = 2'd2,
    OP_BAD    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    TGT_MEM    = 2'd0,
    TGT_PERIPH = 2'd1,
    TGT_UNMAP  = 2'd2,
    TGT_RSVD   = 2'd3
  } target_e;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_RETRY    = 3'd1,
    ST_PERIPH   = 3'd2,
    ST_BAD_OP   = 3'd3,
    ST_UNMAPPED = 3'd4
  } status_e;

  typedef enum logic {
    KIND_REPLY = 1'b0,
    KIND_INVAL = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ACT_REPLY = 2'd0,
    ACT_READ  = 2'd1,
    ACT_WRITE = 2'd2
  } action_e;

  typedef struct packed {
    op_e                     op;
    logic [CPU_W-1:0]        cpu;
    logic                    lock_request;
    logic [ADDRESS_BITS-1:0] address;
    target_e                 target;
  } req_t;

  typedef struct packed {
    kind_e             kind;
    status_e           status;
    logic [CPU_W-1:0]  dest_cpu;
    logic [LINE_W-1:0] line_address;
    logic              last;
  } rsp_t;

  typedef struct packed {
    action_e           action;
    status_e           status;
    logic [CPU_W-1:0]  cpu;
    logic [LINE_W-1:0] line;
  } cmd_t;

  typedef struct packed {
    logic push;
    logic full;
    logic pop;
    logic empty;
  } fifo_ctl_t;

endpackage

### rtl/core/blif_front.sv
module blif_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  blif_pkg::req_t req_i,
  input  logic          cmd_full_i,
  output logic          full_o,
  output logic          cmd_push_o,
  output blif_pkg::cmd_t cmd_o
);

  logic                       lock_held_q, lock_held_d;
  logic [blif_pkg::CPU_W-1:0] lock_owner_q, lock_owner_d;
  logic                       accept;
  logic                       mem_ok;

  assign full_o     = cmd_full_i;
  assign accept     = push_i && !cmd_full_i;
  assign cmd_push_o = accept;

  always_comb begin
    cmd_o.cpu    = req_i.cpu;
    cmd_o.line   = blif_pkg::LINE_W'(req_i.address[blif_pkg::ADDRESS_BITS-1:
                                                  blif_pkg::LINE_OFFSET_BITS]);
    cmd_o.action = blif_pkg::ACT_REPLY;
    cmd_o.status = blif_pkg::ST_DONE;
    mem_ok       = 1'b0;
    priority if (req_i.target == blif_pkg::TGT_PERIPH) begin
      cmd_o.status = blif_pkg::ST_PERIPH;
    end else if (req_i.target != blif_pkg::TGT_MEM) begin
      cmd_o.status = blif_pkg::ST_UNMAPPED;
    end else if (req_i.op == blif_pkg::OP_BAD) begin
      cmd_o.status = blif_pkg::ST_BAD_OP;
    end else if (lock_held_q && lock_owner_q != req_i.cpu) begin
      cmd_o.status = blif_pkg::ST_RETRY;
    end else begin
      mem_ok = 1'b1;
      unique case (req_i.op)
        blif_pkg::OP_READ:  cmd_o.action = blif_pkg::ACT_READ;
        blif_pkg::OP_WRITE: cmd_o.action = blif_pkg::ACT_WRITE;
        default:            cmd_o.action = blif_pkg::ACT_REPLY;
      endcase
    end
  end

  always_comb begin
    lock_held_d  = lock_held_q;
    lock_owner_d = lock_owner_q;
    if (accept && mem_ok) begin
      priority if (req_i.lock_request) begin
        lock_held_d  = 1'b1;
        lock_owner_d = req_i.cpu;
      end else if (req_i.op != blif_pkg::OP_IFETCH && req_i.cpu == lock_owner_q) begin
        lock_held_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_held_q  <= 1'b0;
      lock_owner_q <= '0;
    end else begin
      lock_held_q  <= lock_held_d;
      lock_owner_q <= lock_owner_d;
    end
  end

endmodule

### rtl/core/blif_fifo.sv
module blif_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  blif_pkg::fifo_ctl_t ctl_i,
  output blif_pkg::fifo_ctl_t ctl_o,
  input  blif_pkg::cmd_t      data_i,
  output blif_pkg::cmd_t      data_o
);

  localparam int PtrW = $clog2(blif_pkg::CMD_FIFO_DEPTH);
  localparam int CntW = $clog2(blif_pkg::CMD_FIFO_DEPTH + 1);

  blif_pkg::cmd_t mem_q [blif_pkg::CMD_FIFO_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign ctl_o.full  = count_q == CntW'(blif_pkg::CMD_FIFO_DEPTH);
  assign ctl_o.empty = count_q == '0;
  assign ctl_o.push  = do_push;
  assign ctl_o.pop   = do_pop;
  assign do_push     = ctl_i.push && !ctl_o.full;
  assign do_pop      = ctl_i.pop && !ctl_o.empty;
  assign data_o      = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(blif_pkg::CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(blif_pkg::CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

### rtl/core/blif_back.sv
module blif_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [blif_pkg::CPU_COUNT_W-1:0] cpu_count_i,
  input  logic                             cmd_empty_i,
  input  blif_pkg::cmd_t                   cmd_i,
  output logic                             cmd_pop_o,
  input  logic                             pop_i,
  output logic                             empty_o,
  output blif_pkg::rsp_t                   rsp_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_INVAL,
    S_REPLY
  } state_e;

  state_e                               state_q;
  blif_pkg::cmd_t                       cur_q;
  logic [blif_pkg::CPU_W-1:0]           cnt_q;
  logic [blif_pkg::MAX_CPUS-1:0]        valid_q;
  logic [blif_pkg::LINE_W-1:0]          line_q [blif_pkg::MAX_CPUS];
  blif_pkg::rsp_t                       rsp_q;
  logic                                 rsp_valid_q;
  logic [blif_pkg::CPU_COUNT_W-1:0]     active_n;
  logic                                 can_emit;
  logic                                 needs_inval;
  logic                                 rsp_load;

  assign active_n = (cpu_count_i > blif_pkg::CPU_COUNT_W'(blif_pkg::MAX_CPUS))
                    ? blif_pkg::CPU_COUNT_W'(blif_pkg::MAX_CPUS) : cpu_count_i;
  assign can_emit    = !rsp_valid_q || pop_i;
  assign needs_inval = (blif_pkg::CPU_COUNT_W'(cnt_q) < active_n) && (cnt_q != cur_q.cpu)
                       && (!valid_q[cnt_q] || line_q[cnt_q] != cur_q.line);
  assign rsp_load    = can_emit && ((state_q == S_INVAL && needs_inval) || state_q == S_REPLY);
  assign cmd_pop_o   = (state_q == S_IDLE) && !cmd_empty_i;
  assign empty_o     = !rsp_valid_q;
  assign rsp_o       = rsp_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_INVAL && can_emit && needs_inval) begin
      line_q[cnt_q] <= cur_q.line;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_q       <= '0;
      cnt_q       <= '0;
      valid_q     <= '0;
      rsp_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (pop_i) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (cmd_pop_o) begin
            cur_q   <= cmd_i;
            cnt_q   <= '0;
            state_q <= (cmd_i.action == blif_pkg::ACT_WRITE) ? S_INVAL : S_REPLY;
          end
        end
        S_INVAL: begin
          if (can_emit) begin
            if (needs_inval) begin
              rsp_q.kind         <= blif_pkg::KIND_INVAL;
              rsp_q.status       <= blif_pkg::ST_DONE;
              rsp_q.dest_cpu     <= cnt_q;
              rsp_q.line_address <= cur_q.line;
              rsp_q.last         <= 1'b0;
              valid_q[cnt_q]     <= 1'b1;
            end
            if (cnt_q == blif_pkg::CPU_W'(blif_pkg::MAX_CPUS - 1)) begin
              state_q <= S_REPLY;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
        end
        S_REPLY: begin
          if (can_emit) begin
            rsp_q.kind         <= blif_pkg::KIND_REPLY;
            rsp_q.status       <= cur_q.status;
            rsp_q.dest_cpu     <= cur_q.cpu;
            rsp_q.line_address <= cur_q.line;
            rsp_q.last         <= 1'b1;
            if (cur_q.action != blif_pkg::ACT_REPLY) begin
              valid_q[cur_q.cpu] <= 1'b0;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/bus_lock_and_invalidate_filter.sv
// Bus lock and invalidate filter. Requests enter through a push/full queue
// port and are classified at once by the front end, which also owns the
// global atomic lock, so lock decisions follow request order exactly. A
// two-entry command queue feeds the back end, which owns the per-cpu
// last-invalidated lines and issues results through a one-entry output
// register read with empty/pop. The back end loads a command, then for a
// write checks each of the four cpu slots in turn, sending invalidates
// where needed, then sends the reply; a result left waiting on pop stalls
// it. Each request ends with exactly one reply with last set, preceded by
// zero to three invalidates. cpu_count is written through cfg_we_i/cfg_wdata_i
// and resets to 1; the user must write it only while the block is idle, as
// the block itself does not enforce this.
module bus_lock_and_invalidate_filter (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [blif_pkg::CPU_COUNT_W-1:0] cfg_wdata_i,
  input  logic                             push_i,
  output logic                             full_o,
  input  blif_pkg::req_t                   req_i,
  output logic                             empty_o,
  input  logic                             pop_i,
  output blif_pkg::rsp_t                   rsp_o
);

  logic [blif_pkg::CPU_COUNT_W-1:0] cpu_count_q;
  blif_pkg::fifo_ctl_t              fifo_in, fifo_out;
  blif_pkg::cmd_t                   cmd_wr, cmd_rd;
  logic                             cmd_push, cmd_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpu_count_q <= blif_pkg::CPU_COUNT_W'(1);
    end else if (cfg_we_i) begin
      cpu_count_q <= cfg_wdata_i;
    end
  end

  blif_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .req_i      (req_i),
    .cmd_full_i (fifo_out.full),
    .full_o     (full_o),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_wr)
  );

  always_comb begin
    fifo_in       = '0;
    fifo_in.push  = cmd_push;
    fifo_in.pop   = cmd_pop;
  end

  blif_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (fifo_in),
    .ctl_o  (fifo_out),
    .data_i (cmd_wr),
    .data_o (cmd_rd)
  );

  blif_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cpu_count_i (cpu_count_q),
    .cmd_empty_i (fifo_out.empty),
    .cmd_i       (cmd_rd),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop_i),
    .empty_o     (empty_o),
    .rsp_o       (rsp_o)
  );

endmodule

### rtl/core/blif_checker.sv
module blif_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           empty_o,
  input logic           pop_i,
  input blif_pkg::rsp_t rsp_o
);

  // waiting result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(rsp_o)))
    else $error("result changed before pop");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && rsp_o.kind == blif_pkg::KIND_INVAL) |->
      (!rsp_o.last && rsp_o.status == blif_pkg::ST_DONE))
    else $error("bad invalidate");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && rsp_o.kind == blif_pkg::KIND_REPLY) |-> rsp_o.last)
    else $error("reply without last");

  // an invalidate is followed by more results of the same request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && pop_i && rsp_o.kind == blif_pkg::KIND_INVAL) |-> ##[1:4] !empty_o)
    else $error("request ended on invalidate");

endmodule

bind bus_lock_and_invalidate_filter blif_checker u_blif_checker (.*);

### tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import blif_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 45;
  localparam int SETTLE_CYCLES = 10;

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t reply;
  } stim_row_t;

  logic                   clk;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CPU_COUNT_W-1:0] cfg_wdata_i;
  logic                   push_i;
  logic                   full_o;
  req_t                   req_i;
  logic                   empty_o;
  logic                   pop_i;
  rsp_t                   rsp_o;

  // predictor state
  logic [CPU_COUNT_W-1:0] active_cpus;
  logic                   lk_held;
  logic [CPU_W-1:0]       lk_owner;
  logic [LINE_W-1:0]      inv_line [MAX_CPUS];
  logic [MAX_CPUS-1:0]    inv_valid;

  rsp_t      msgs_due [$];
  stim_row_t plan [$];
  int        fault_count;
  int        idle_cycles;
  bit        hold_ask;
  bit        calm;

  // locked sequence generator state
  logic [CPU_W-1:0]  chain_cpu;
  int                chain_left;
  logic [LINE_W-1:0] hot_lines [4];

  bus_lock_and_invalidate_filter dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push_i),
    .full_o      (full_o),
    .req_i       (req_i),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .rsp_o       (rsp_o)
  );

  always #4 clk = ~clk;

  function automatic rsp_t make_msg(kind_e k, status_e s, logic [CPU_W-1:0] dest,
                                    logic [LINE_W-1:0] ln, logic lst);
    rsp_t m;
    m.kind         = k;
    m.status       = s;
    m.dest_cpu     = dest;
    m.line_address = ln;
    m.last         = lst;
    return m;
  endfunction

  function automatic void predict_messages(req_t r);
    logic [LINE_W-1:0] ln;
    int n;
    ln = r.address[ADDRESS_BITS-1:LINE_OFFSET_BITS];
    n  = (active_cpus > MAX_CPUS) ? MAX_CPUS : int'(active_cpus);
    if (r.target == TGT_PERIPH) begin
      msgs_due.push_back(make_msg(KIND_REPLY, ST_PERIPH, r.cpu, ln, 1'b1));
      return;
    end
    if (r.target != TGT_MEM) begin
      msgs_due.push_back(make_msg(KIND_REPLY, ST_UNMAPPED, r.cpu, ln, 1'b1));
      return;
    end
    if (r.op == OP_BAD) begin
      msgs_due.push_back(make_msg(KIND_REPLY, ST_BAD_OP, r.cpu, ln, 1'b1));
      return;
    end
    if (lk_held && lk_owner != r.cpu) begin
      msgs_due.push_back(make_msg(KIND_REPLY, ST_RETRY, r.cpu, ln, 1'b1));
      return;
    end
    if (r.lock_request) begin
      lk_held  = 1'b1;
      lk_owner = r.cpu;
    end
    if (r.op == OP_READ) begin
      inv_valid[r.cpu] = 1'b0;
    end else if (r.op == OP_WRITE) begin
      for (int c = 0; c < n; c++) begin
        if (c != int'(r.cpu) && (!inv_valid[c] || inv_line[c] != ln)) begin
          msgs_due.push_back(make_msg(KIND_INVAL, ST_DONE, CPU_W'(c), ln, 1'b0));
          inv_line[c]  = ln;
          inv_valid[c] = 1'b1;
        end
      end
      inv_valid[r.cpu] = 1'b0;
    end
    if (r.op != OP_IFETCH && r.cpu == lk_owner && !r.lock_request && lk_held) begin
      lk_held = 1'b0;
    end
    msgs_due.push_back(make_msg(KIND_REPLY, ST_DONE, r.cpu, ln, 1'b1));
  endfunction

  function automatic req_t mk_req(op_e op, int cpu, bit lk, logic [31:0] a, target_e t);
    req_t r;
    r.op           = op;
    r.cpu          = cpu[CPU_W-1:0];
    r.lock_request = lk;
    r.address      = a;
    r.target       = t;
    return r;
  endfunction

  function automatic rsp_t mk_reply(status_e s, int cpu, logic [LINE_W-1:0] ln);
    return make_msg(KIND_REPLY, s, cpu[CPU_W-1:0], ln, 1'b1);
  endfunction

  function automatic void add_row(req_t r, bit typed, rsp_t reply);
    stim_row_t row;
    row.req   = r;
    row.typed = typed;
    row.reply = reply;
    plan.push_back(row);
  endfunction

  function automatic req_t random_request();
    req_t r;
    r.cpu          = CPU_W'($urandom_range(0, 3));
    r.lock_request = ($urandom_range(0, 3) == 0);
    r.op           = ($urandom_range(0, 9) == 0) ? OP_BAD : op_e'($urandom_range(0, 2));
    case ($urandom_range(0, 9))
      0:       r.target = TGT_PERIPH;
      1:       r.target = TGT_UNMAP;
      2:       r.target = TGT_RSVD;
      default: r.target = TGT_MEM;
    endcase
    if (chain_left == 0 && $urandom_range(0, 4) == 0) begin
      chain_cpu  = CPU_W'($urandom_range(0, 3));
      chain_left = $urandom_range(2, 5);
    end
    if (chain_left != 0 && $urandom_range(0, 2) != 0) begin
      chain_left--;
      r.cpu          = chain_cpu;
      r.target       = TGT_MEM;
      r.op           = (chain_left == 0) ? OP_WRITE : op_e'($urandom_range(0, 2));
      r.lock_request = (chain_left != 0);
    end
    if ($urandom_range(0, 3) == 0) begin
      r.address = $urandom();
    end else begin
      r.address = {hot_lines[$urandom_range(0, 3)], 6'($urandom_range(0, 63))};
    end
    return r;
  endfunction

  task automatic send_request(req_t r, bit typed, rsp_t reply);
    push_i <= 1'b1;
    req_i  <= r;
    @(posedge clk);
    while (full_o) @(posedge clk);
    if (typed) begin
      msgs_due.push_back(reply);
    end else begin
      predict_messages(r);
    end
    if (!calm && $urandom_range(0, 3) == 0) begin
      push_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic write_cpu_count(logic [CPU_COUNT_W-1:0] value);
    push_i <= 1'b0;
    while (msgs_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk);
    cfg_we_i    <= 1'b0;
    active_cpus = value;
  endtask

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fault_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    rsp_t want;
    if (rst_ni && pop_i && !empty_o) begin
      if (msgs_due.size() == 0) begin
        $display("%0t: unexpected message, expected none, actual %p", $time, rsp_o);
        fault_count++;
      end else begin
        want = msgs_due.pop_front();
        compare_field("kind", 32'(want.kind), 32'(rsp_o.kind));
        compare_field("status", 32'(want.status), 32'(rsp_o.status));
        compare_field("dest_cpu", 32'(want.dest_cpu), 32'(rsp_o.dest_cpu));
        compare_field("line_address", 32'(want.line_address), 32'(rsp_o.line_address));
        compare_field("last", 32'(want.last), 32'(rsp_o.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((push_i && !full_o) || (pop_i && !empty_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side
  initial begin
    forever begin
      if (hold_ask) begin
        pop_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_ask = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        pop_i <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        pop_i <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    logic [CPU_COUNT_W-1:0] cfg_plan [8];
    clk         = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    push_i      = 1'b0;
    req_i       = '0;
    fault_count = 0;
    idle_cycles = 0;
    hold_ask    = 1'b0;
    calm        = 1'b0;
    chain_cpu   = '0;
    chain_left  = 0;
    active_cpus = 3'd1;
    lk_held     = 1'b0;
    lk_owner    = '0;
    inv_valid   = '0;
    hot_lines   = '{26'h0, 26'h3ffffff, LINE_W'($urandom()), LINE_W'($urandom())};
    cfg_plan    = '{3'd1, 3'd0, 3'd7, 3'd2, 3'd5, 3'd3, 3'd6, 3'd4};

    repeat (8) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // directed requests, four cpus active
    add_row(mk_req(OP_IFETCH, 0, 0, 32'h0000_0000, TGT_PERIPH), 1, mk_reply(ST_PERIPH, 0, 26'h0));
    add_row(mk_req(OP_WRITE, 3, 0, 32'hffff_ffff, TGT_UNMAP), 1,
            mk_reply(ST_UNMAPPED, 3, 26'h3ffffff));
    add_row(mk_req(OP_READ, 1, 1, 32'h8000_0000, TGT_RSVD), 1,
            mk_reply(ST_UNMAPPED, 1, 26'h2000000));
    add_row(mk_req(OP_BAD, 2, 0, 32'h0000_003f, TGT_MEM), 1, mk_reply(ST_BAD_OP, 2, 26'h0));
    add_row(mk_req(OP_BAD, 1, 1, 32'h1234_5678, TGT_PERIPH), 1,
            mk_reply(ST_PERIPH, 1, 26'h048d159));
    add_row(mk_req(OP_WRITE, 0, 0, 32'h0000_1000, TGT_MEM), 0, '0);
    add_row(mk_req(OP_WRITE, 1, 0, 32'h0000_1000, TGT_MEM), 0, '0);
    add_row(mk_req(OP_READ, 2, 0, 32'h0000_1000, TGT_MEM), 0, '0);
    add_row(mk_req(OP_WRITE, 3, 1, 32'hffff_ffc0, TGT_MEM), 0, '0);
    add_row(mk_req(OP_READ, 0, 0, 32'h0000_0000, TGT_MEM), 1, mk_reply(ST_RETRY, 0, 26'h0));
    add_row(mk_req(OP_READ, 0, 0, 32'h0000_0040, TGT_PERIPH), 1, mk_reply(ST_PERIPH, 0, 26'h1));
    add_row(mk_req(OP_IFETCH, 3, 0, 32'h0000_0080, TGT_MEM), 0, '0);
    add_row(mk_req(OP_WRITE, 2, 1, 32'h0000_2000, TGT_MEM), 1, mk_reply(ST_RETRY, 2, 26'h80));
    add_row(mk_req(OP_READ, 3, 1, 32'h0000_0040, TGT_MEM), 0, '0);
    add_row(mk_req(OP_WRITE, 3, 0, 32'h0000_0040, TGT_MEM), 0, '0);
    add_row(mk_req(OP_READ, 1, 0, 32'h0000_0100, TGT_MEM), 0, '0);
    add_row(mk_req(OP_IFETCH, 1, 1, 32'h0000_0140, TGT_MEM), 0, '0);
    add_row(mk_req(OP_BAD, 2, 1, 32'h0000_0040, TGT_MEM), 1, mk_reply(ST_BAD_OP, 2, 26'h1));
    add_row(mk_req(OP_IFETCH, 0, 0, 32'h0000_1000, TGT_MEM), 1, mk_reply(ST_RETRY, 0, 26'h40));
    add_row(mk_req(OP_READ, 1, 0, 32'h0000_0140, TGT_MEM), 0, '0);
    add_row(mk_req(OP_WRITE, 3, 0, 32'h7fff_ffff, TGT_MEM), 0, '0);
    add_row(mk_req(OP_WRITE, 3, 0, 32'h7fff_ffc1, TGT_MEM), 0, '0);
    add_row(mk_req(OP_READ, 1, 0, 32'hffff_ffff, TGT_MEM), 0, '0);

    write_cpu_count(3'd4);
    foreach (plan[i]) send_request(plan[i].req, plan[i].typed, plan[i].reply);

    foreach (cfg_plan[p]) begin
      write_cpu_count(cfg_plan[p]);
      if (p == 2) hold_ask = 1'b1;
      if (p == 7) calm = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) send_request(random_request(), 0, '0);
    end

    push_i <= 1'b0;
    while (msgs_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
